FILE: rtl/pbsb_pkg.sv
// Shared constants and types for the page buffer sprite blitter.
package pbsb_pkg;

  localparam int DEFAULT_COLUMNS = 128;
  localparam int DEFAULT_PAGES   = 8;
  localparam int PIXEL_W         = 8;
  localparam int ROW_W           = 5;
  localparam int COL_W           = 10;

  localparam logic FUNC_BLIT = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic               en;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [PIXEL_W-1:0] bits;
  } bank_wr_t;

endpackage

FILE: rtl/pbsb_ram.sv
// Generic simple dual-port RAM with per-bit write enables and registered read.
module pbsb_ram import pbsb_pkg::*; #(
  parameter int WIDTH = PIXEL_W,
  parameter int DEPTH = DEFAULT_COLUMNS
) (
  input  logic                     clk,
  input  logic [WIDTH-1:0]         wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    for (int i = 0; i < WIDTH; i++) begin
      if (wr_en[i]) begin
        mem[wr_addr][i] <= wr_data[i];
      end
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/pbsb_geom.sv
// Blit geometry: clipping, vertical shift and split of one sprite byte over two page banks.
module pbsb_geom import pbsb_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEFAULT_COLUMNS,
  parameter int SCREEN_PAGES   = DEFAULT_PAGES
) (
  input  logic signed [9:0]  x_origin,
  input  logic signed [9:0]  y_origin,
  input  logic [5:0]         col_offset,
  input  logic [2:0]         page_offset,
  input  logic [7:0]         sprite_byte,
  output bank_wr_t           wr_even,
  output bank_wr_t           wr_odd
);

  logic signed [10:0] col;
  logic               col_ok;
  logic signed [7:0]  page_lo;
  logic signed [7:0]  page_hi;
  logic               lo_ok;
  logic               hi_ok;
  logic [15:0]        shifted;
  bank_wr_t           lo_wr;
  bank_wr_t           hi_wr;

  always_comb begin
    col     = $signed({x_origin[9], x_origin}) + $signed({5'b0, col_offset});
    col_ok  = !col[10] && (32'(col[9:0]) < 32'(SCREEN_COLUMNS));
    page_lo = $signed({y_origin[9], y_origin[9:3]}) + $signed({5'b0, page_offset});
    page_hi = page_lo + 8'sd1;
    lo_ok   = !page_lo[7] && (32'(page_lo[6:0]) < 32'(SCREEN_PAGES));
    hi_ok   = !page_hi[7] && (32'(page_hi[6:0]) < 32'(SCREEN_PAGES));
    shifted = {8'b0, sprite_byte} << y_origin[2:0];

    lo_wr.en   = col_ok && lo_ok;
    lo_wr.row  = page_lo[ROW_W:1];
    lo_wr.col  = col[COL_W-1:0];
    lo_wr.bits = shifted[7:0];

    hi_wr.en   = col_ok && hi_ok;
    hi_wr.row  = page_hi[ROW_W:1];
    hi_wr.col  = col[COL_W-1:0];
    hi_wr.bits = shifted[15:8];

    if (!page_lo[0]) begin
      wr_even = lo_wr;
      wr_odd  = hi_wr;
    end else begin
      wr_even = hi_wr;
      wr_odd  = lo_wr;
    end
  end

endmodule

FILE: rtl/page_buffer_sprite_blitter.sv
// Top level of the page buffer sprite blitter: input stage, framebuffer banks and result register.
//
// The block keeps a monochrome framebuffer of SCREEN_PAGES pages by SCREEN_COLUMNS columns,
// stored as two banks of even and odd pages with per-bit write enables, so a blit ORs its two
// shifted bytes into both pages in the same cycle without a read-modify-write. One item is
// taken per cycle while in_stall is low, blits and reads mixed freely; a read that waits on a
// stalled output holds in_stall high. A read result passes the input register, the registered
// RAM read and the output register, and leaves on an edge at which the output is not stalled.
// After reset the block clears the framebuffer, one address of each bank per cycle, and holds
// in_stall high until all ((SCREEN_PAGES + 1) / 2) * SCREEN_COLUMNS addresses of each bank
// (512 with the default geometry) are cleared. Reads outside the screen return zero.
module page_buffer_sprite_blitter import pbsb_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEFAULT_COLUMNS,
  parameter int SCREEN_PAGES   = DEFAULT_PAGES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              func,
  input  logic signed [9:0] x_origin,
  input  logic signed [9:0] y_origin,
  input  logic [5:0]        col_offset,
  input  logic [2:0]        page_offset,
  input  logic [7:0]        sprite_byte,
  input  logic [2:0]        read_page,
  input  logic [6:0]        read_column,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        read_data
);

  localparam int BANK_ROWS  = (SCREEN_PAGES + 1) / 2;
  localparam int BANK_DEPTH = BANK_ROWS * SCREEN_COLUMNS;
  localparam int AW         = $clog2(BANK_DEPTH);

  logic              s1_valid;
  logic              s1_func;
  logic signed [9:0] s1_x;
  logic signed [9:0] s1_y;
  logic [5:0]        s1_col_offset;
  logic [2:0]        s1_page_offset;
  logic [7:0]        s1_byte;
  logic [2:0]        s1_read_page;
  logic [6:0]        s1_read_column;

  logic              s2_valid;
  logic              s2_bank;
  logic              s2_zero;

  logic              clearing;
  logic [AW-1:0]     clr_addr;

  logic              out_free;
  logic              s2_free;
  logic              s1_go;
  logic              s1_free;
  logic              in_take;
  logic              rd_go;
  logic              blit_go;
  logic              rd_ok;

  bank_wr_t          wr_even;
  bank_wr_t          wr_odd;
  logic [AW-1:0]     addr_even;
  logic [AW-1:0]     addr_odd;
  logic [AW-1:0]     rd_addr;
  logic [7:0]        en_even;
  logic [7:0]        en_odd;
  logic [7:0]        wdata;
  logic [7:0]        rd_even;
  logic [7:0]        rd_odd;

  pbsb_geom #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_PAGES  (SCREEN_PAGES)
  ) u_geom (
    .x_origin   (s1_x),
    .y_origin   (s1_y),
    .col_offset (s1_col_offset),
    .page_offset(s1_page_offset),
    .sprite_byte(s1_byte),
    .wr_even    (wr_even),
    .wr_odd     (wr_odd)
  );

  always_comb begin
    out_free = !out_valid || !out_stall;
    s2_free  = !s2_valid || out_free;
    s1_go    = s1_valid && (s1_func == FUNC_BLIT || s2_free);
    s1_free  = !s1_valid || s1_go;
    in_stall = clearing || !s1_free;
    in_take  = in_valid && !in_stall;
    rd_go    = s1_go && s1_func == FUNC_READ;
    blit_go  = s1_go && s1_func == FUNC_BLIT;
    rd_ok    = 32'(s1_read_page) < 32'(SCREEN_PAGES) &&
               32'(s1_read_column) < 32'(SCREEN_COLUMNS);

    addr_even = AW'(32'(wr_even.row) * 32'(SCREEN_COLUMNS) + 32'(wr_even.col));
    addr_odd  = AW'(32'(wr_odd.row) * 32'(SCREEN_COLUMNS) + 32'(wr_odd.col));
    rd_addr   = rd_ok ? AW'(32'(s1_read_page[2:1]) * 32'(SCREEN_COLUMNS) +
                            32'(s1_read_column)) : '0;

    if (clearing) begin
      en_even   = 8'hFF;
      en_odd    = 8'hFF;
      wdata     = 8'h00;
      addr_even = clr_addr;
      addr_odd  = clr_addr;
    end else begin
      en_even = (blit_go && wr_even.en) ? wr_even.bits : 8'h00;
      en_odd  = (blit_go && wr_odd.en) ? wr_odd.bits : 8'h00;
      wdata   = 8'hFF;
    end
  end

  pbsb_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(BANK_DEPTH)
  ) u_ram_even (
    .clk    (clk),
    .wr_en  (en_even),
    .wr_addr(addr_even),
    .wr_data(wdata),
    .rd_en  (rd_go),
    .rd_addr(rd_addr),
    .rd_data(rd_even)
  );

  pbsb_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(BANK_DEPTH)
  ) u_ram_odd (
    .clk    (clk),
    .wr_en  (en_odd),
    .wr_addr(addr_odd),
    .wr_data(wdata),
    .rd_en  (rd_go),
    .rd_addr(rd_addr),
    .rd_data(rd_odd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_addr == AW'(BANK_DEPTH - 1)) begin
          clearing <= 1'b0;
        end else begin
          clr_addr <= clr_addr + AW'(1);
        end
      end

      if (s1_free) begin
        s1_valid <= in_take;
      end

      if (s2_free) begin
        s2_valid <= rd_go;
      end

      if (out_free && s2_valid) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_func        <= func;
      s1_x           <= x_origin;
      s1_y           <= y_origin;
      s1_col_offset  <= col_offset;
      s1_page_offset <= page_offset;
      s1_byte        <= sprite_byte;
      s1_read_page   <= read_page;
      s1_read_column <= read_column;
    end
    if (rd_go) begin
      s2_bank <= s1_read_page[0];
      s2_zero <= !rd_ok;
    end
    if (out_free && s2_valid) begin
      if (s2_zero) begin
        read_data <= 8'h00;
      end else if (s2_bank) begin
        read_data <= rd_odd;
      end else begin
        read_data <= rd_even;
      end
    end
  end

endmodule

FILE: tb/page_buffer_sprite_blitter_checker.sv
`timescale 1ns / 1ps
// Checker for the page buffer sprite blitter: predicts the framebuffer and compares read data.
module page_buffer_sprite_blitter_checker import pbsb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              func,
  input  logic signed [9:0] x_origin,
  input  logic signed [9:0] y_origin,
  input  logic [5:0]        col_offset,
  input  logic [2:0]        page_offset,
  input  logic [7:0]        sprite_byte,
  input  logic [2:0]        read_page,
  input  logic [6:0]        read_column,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [7:0]        read_data,
  output int                fail_count,
  output int                pending
);

  localparam int COLUMNS = DEFAULT_COLUMNS;
  localparam int PAGES   = DEFAULT_PAGES;

  logic [7:0] frame_bytes [COLUMNS*PAGES];
  logic [7:0] expected_reads [$];
  logic [7:0] wanted;
  int         fails = 0;

  function automatic void or_into_frame(int page, int column, logic [7:0] bits);
    if (page >= 0 && page < PAGES && column >= 0 && column < COLUMNS) begin
      frame_bytes[page*COLUMNS + column] |= bits;
    end
  endfunction

  function automatic void blit_into_frame(logic signed [9:0] xo, logic signed [9:0] yo,
                                          logic [5:0] co, logic [2:0] po, logic [7:0] bits);
    int          column;
    int          page;
    logic [15:0] spread;
    column = int'(xo) + int'(co);
    page   = (int'(yo) >>> 3) + int'(po);
    spread = {8'h00, bits} << yo[2:0];
    if (bits != 8'h00 && column >= 0 && column < COLUMNS) begin
      or_into_frame(page, column, spread[7:0]);
      or_into_frame(page + 1, column, spread[15:8]);
    end
  endfunction

  function automatic logic [7:0] frame_byte_at(logic [2:0] rp, logic [6:0] rc);
    if (int'(rp) < PAGES && int'(rc) < COLUMNS) begin
      return frame_bytes[int'(rp)*COLUMNS + int'(rc)];
    end
    return 8'h00;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (frame_bytes[a]) frame_bytes[a] = 8'h00;
      expected_reads.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reads.size() == 0) begin
          if (fails < 10) begin
            $display("%0t: read result %02h with no read pending", $time, read_data);
          end
          fails++;
        end else begin
          wanted = expected_reads.pop_front();
          if (read_data !== wanted) begin
            if (fails < 10) begin
              $display("%0t: read_data mismatch, expected %02h, got %02h",
                       $time, wanted, read_data);
            end
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (func == FUNC_BLIT) begin
          blit_into_frame(x_origin, y_origin, col_offset, page_offset, sprite_byte);
        end else begin
          expected_reads.push_back(frame_byte_at(read_page, read_column));
        end
      end
    end
    fail_count <= fails;
    pending    <= expected_reads.size();
  end

endmodule

FILE: tb/page_buffer_sprite_blitter_tb.sv
`timescale 1ns / 1ps
// Testbench top for the page buffer sprite blitter: clock, reset, stimulus and verdict.
module page_buffer_sprite_blitter_tb;
  import pbsb_pkg::*;

  localparam int IDLE_LIMIT      = 4000;
  localparam int RANDOM_REQUESTS = 1480;
  localparam int DRAIN_CYCLES    = 10;

  typedef struct {
    logic              func;
    logic signed [9:0] x_origin;
    logic signed [9:0] y_origin;
    logic [5:0]        col_offset;
    logic [2:0]        page_offset;
    logic [7:0]        sprite_byte;
    logic [2:0]        read_page;
    logic [6:0]        read_column;
  } request_t;

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  logic              func        = FUNC_READ;
  logic signed [9:0] x_origin    = '0;
  logic signed [9:0] y_origin    = '0;
  logic [5:0]        col_offset  = '0;
  logic [2:0]        page_offset = '0;
  logic [7:0]        sprite_byte = '0;
  logic [2:0]        read_page   = '0;
  logic [6:0]        read_column = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  logic [7:0]        read_data;
  int                fail_count;
  int                pending;
  int                idle_cycles = 0;
  int                steady_left = 0;

  always #1 clk = ~clk;

  page_buffer_sprite_blitter dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .x_origin(x_origin), .y_origin(y_origin),
    .col_offset(col_offset), .page_offset(page_offset), .sprite_byte(sprite_byte),
    .read_page(read_page), .read_column(read_column),
    .out_valid(out_valid), .out_stall(out_stall), .read_data(read_data)
  );

  page_buffer_sprite_blitter_checker frame_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .x_origin(x_origin), .y_origin(y_origin),
    .col_offset(col_offset), .page_offset(page_offset), .sprite_byte(sprite_byte),
    .read_page(read_page), .read_column(read_column),
    .out_valid(out_valid), .out_stall(out_stall), .read_data(read_data),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic request_t any_request();
    request_t r;
    r.func        = 1'($urandom_range(0, 1));
    r.x_origin    = 10'($urandom);
    r.y_origin    = 10'($urandom);
    r.col_offset  = 6'($urandom);
    r.page_offset = 3'($urandom);
    r.sprite_byte = 8'($urandom);
    r.read_page   = 3'($urandom);
    r.read_column = 7'($urandom);
    return r;
  endfunction

  task automatic issue_request(input request_t r);
    int gap;
    if (steady_left > 0) begin
      steady_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 39) == 0) steady_left = $urandom_range(20, 80);
      gap = idle_len();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    func        <= r.func;
    x_origin    <= r.x_origin;
    y_origin    <= r.y_origin;
    col_offset  <= r.col_offset;
    page_offset <= r.page_offset;
    sprite_byte <= r.sprite_byte;
    read_page   <= r.read_page;
    read_column <= r.read_column;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic blit_at(input int xo, input int yo, input int co, input int po,
                         input logic [7:0] bits);
    request_t r;
    r             = any_request();
    r.func        = FUNC_BLIT;
    r.x_origin    = 10'(xo);
    r.y_origin    = 10'(yo);
    r.col_offset  = 6'(co);
    r.page_offset = 3'(po);
    r.sprite_byte = bits;
    issue_request(r);
  endtask

  task automatic read_at(input int rp, input int rc);
    request_t r;
    r             = any_request();
    r.func        = FUNC_READ;
    r.read_page   = 3'(rp);
    r.read_column = 7'(rc);
    issue_request(r);
  endtask

  initial begin : out_stall_gen
    int run;
    forever begin
      out_stall <= 1'b0;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      repeat (run) @(negedge clk);
      run = idle_len();
      if (run > 0) begin
        out_stall <= 1'b1;
        repeat (run) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    request_t r;
    int       pick;
    int       column;
    int       target_row;
    int       last_page;
    int       last_column;
    last_page   = 0;
    last_column = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    read_at(0, 0);
    blit_at(0, 0, 0, 0, 8'h00);
    read_at(0, 0);
    blit_at(0, 0, 0, 0, 8'hFF);
    blit_at(64, 3, 63, 7, 8'h81);
    read_at(7, 127);
    blit_at(-5, -3, 6, 0, 8'hA5);
    read_at(0, 1);
    blit_at(10, 7, 0, 0, 8'hFF);
    read_at(0, 10);
    read_at(1, 10);
    blit_at(-512, 0, 63, 0, 8'hFF);
    blit_at(511, 0, 0, 0, 8'hFF);
    blit_at(65, 0, 63, 0, 8'hFF);
    blit_at(-1, 0, 0, 0, 8'hFF);
    blit_at(20, -512, 0, 7, 8'hFF);
    blit_at(20, 511, 0, 0, 8'hFF);
    blit_at(30, 60, 0, 0, 8'h3C);
    read_at(7, 30);
    read_at(0, 0);
    read_at(0, 127);
    read_at(7, 0);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      r    = any_request();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        r.func        = FUNC_BLIT;
        r.col_offset  = 6'($urandom_range(0, 63));
        column        = $urandom_range(0, 135);
        column        = column - 4;
        r.x_origin    = 10'(column - int'(r.col_offset));
        r.page_offset = 3'($urandom_range(0, 7));
        target_row    = $urandom_range(0, 72);
        target_row    = target_row - 8;
        r.y_origin    = 10'(target_row - 8 * int'(r.page_offset));
        last_column   = column;
        last_page     = target_row >>> 3;
      end else if (pick < 55) begin
        r.func = FUNC_BLIT;
      end else if (pick < 80) begin
        r.func        = FUNC_READ;
        r.read_page   = 3'(last_page + $urandom_range(0, 1));
        r.read_column = 7'(last_column);
      end else begin
        r.func = FUNC_READ;
      end
      issue_request(r);
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: page_buffer_sprite_blitter.f
rtl/pbsb_pkg.sv
rtl/pbsb_ram.sv
rtl/pbsb_geom.sv
rtl/page_buffer_sprite_blitter.sv
tb/page_buffer_sprite_blitter_checker.sv
tb/page_buffer_sprite_blitter_tb.sv
